>>> src/onewire_transaction_sequencer_macros.svh
// Assertion macros shared by the checker of the one-wire sequencer
`ifndef ONEWIRE_TRANSACTION_SEQUENCER_MACROS_SVH
`define ONEWIRE_TRANSACTION_SEQUENCER_MACROS_SVH

// Same-cycle implication, ignored while reset is low
`define OWT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("one-wire sequencer: implication check failed");

// Next-cycle implication, ignored while reset is low
`define OWT_ASSERT_NEXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("one-wire sequencer: next-cycle check failed");

// Implication checked through reset as well
`define OWT_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("one-wire sequencer: reset check failed");

`endif

>>> src/owt_pkg.sv
// Types and constants of the one-wire transaction sequencer
package owt_pkg;

    // input cmd codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_ECHO  = 2'd2;

    // line characters
    localparam logic [7:0] RESET_CHAR    = 8'hf0;
    localparam logic [7:0] ONE_CHAR      = 8'hff;
    localparam logic [7:0] ZERO_CHAR     = 8'h00;
    localparam logic [7:0] ONE_THRESHOLD = 8'hfe;

    // ROM and function commands
    localparam logic [7:0] ROM_READ  = 8'h33;
    localparam logic [7:0] ROM_MATCH = 8'h55;
    localparam logic [7:0] FN_WRITE  = 8'h4e;
    localparam logic [7:0] FN_READ   = 8'hbe;

    // reflected Dallas CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8c;

    // line rates: reset slot at 9600 baud, data slots at 115200 baud
    localparam int SLOW_BAUD = 9600;
    localparam int FAST_BAUD = 115200;

    localparam int ROM_BYTES      = 8;
    localparam int SP_WRITE_BYTES = 3;
    localparam int SP_READ_BYTES  = 9;
    localparam int SP_BASE        = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rom_command;
        logic [7:0] function_command;
        logic [3:0] write_index;
        logic [7:0] write_value;
        logic [7:0] echo_char;
    } t_in_item;

    typedef struct packed {
        logic       line_char_valid;
        logic [7:0] line_char;
        logic       slow_rate;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_from_rom;
        logic [3:0] read_index;
        logic       finished;
        logic       no_device;
        logic       crc_good;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_START,
        OP_LOAD,
        OP_ECHO
    } t_op;

    // classified request as held in the queue
    typedef struct packed {
        t_op        op;
        logic [7:0] rom_command;
        logic [7:0] function_command;
        logic [3:0] write_index;
        logic [7:0] write_value;
        logic       echo_one;
        logic       echo_reset;
    } t_req;

endpackage

>>> src/owt_front.sv
// Front end: accepts input requests and classifies them for the queue
module owt_front (
    input  logic              i_in_valid,
    input  owt_pkg::t_in_item i_in,
    input  logic              i_full,
    output logic              o_in_stall,
    output logic              o_push,
    output owt_pkg::t_req     o_req
);

    logic known;

    assign o_in_stall = i_full;

    always_comb begin
        known                  = 1'b1;
        o_req.op               = owt_pkg::OP_ECHO;
        o_req.rom_command      = i_in.rom_command;
        o_req.function_command = i_in.function_command;
        o_req.write_index      = i_in.write_index;
        o_req.write_value      = i_in.write_value;
        o_req.echo_one         = (i_in.echo_char >= owt_pkg::ONE_THRESHOLD);
        o_req.echo_reset       = (i_in.echo_char == owt_pkg::RESET_CHAR);
        case (i_in.cmd)
            owt_pkg::CMD_START: o_req.op = owt_pkg::OP_START;
            owt_pkg::CMD_LOAD: o_req.op = owt_pkg::OP_LOAD;
            owt_pkg::CMD_ECHO: o_req.op = owt_pkg::OP_ECHO;
            default: known = 1'b0;   // unused code: taken and dropped
        endcase
    end

    assign o_push = i_in_valid && !i_full && known;

endmodule

>>> src/owt_queue.sv
// Short request queue between front and back end
module owt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  owt_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_valid,
    output owt_pkg::t_req o_req,
    input  logic          i_pop
);

    owt_pkg::t_req                r_slot [owt_pkg::QUEUE_DEPTH];
    logic [owt_pkg::QAW-1:0]      r_wr_ptr;
    logic [owt_pkg::QAW-1:0]      r_rd_ptr;
    logic [owt_pkg::QAW:0]        r_count;
    logic                         do_pop;

    assign o_full  = (r_count == (owt_pkg::QAW + 1)'(owt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wr_ptr] <= i_req;
                r_wr_ptr         <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/owt_back.sv
// Back end: transaction state machine, write store, CRC and result register
module owt_back #(
    parameter int STORE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  owt_pkg::t_req      i_req,
    output logic               o_pop,
    output logic               o_out_valid,
    output owt_pkg::t_out_item o_out,
    input  logic               i_out_stall
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = (AW > 5) ? AW : 5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRESENCE,
        PH_ROM_CMD,
        PH_ROM_DATA,
        PH_FN_CMD,
        PH_FN_DATA
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [2:0]         r_bit_pos, n_bit_pos;
    logic [3:0]         r_byte_pos, n_byte_pos;
    logic [7:0]         r_asm, n_asm;
    logic [7:0]         r_send, n_send;
    logic [7:0]         r_rom_cmd, n_rom_cmd;
    logic [7:0]         r_fn_cmd, n_fn_cmd;
    logic [7:0]         r_crc, n_crc;
    logic               r_out_valid;
    owt_pkg::t_out_item r_out;

    logic [7:0]         r_store [STORE_DEPTH];
    logic [7:0]         r_rd_data;

    logic               fire;
    logic               has_res;
    owt_pkg::t_out_item res;
    logic               rd;
    logic               go_rd;
    logic               go;
    t_phase             go_ph;
    logic [7:0]         sel;
    logic [7:0]         asm_upd;
    logic [7:0]         crc_upd;
    logic [3:0]         sp_count;
    logic               st_we;
    logic [AW-1:0]      st_waddr;
    logic [FW-1:0]      pa;
    logic               pa_ok;

    assign fire  = i_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = fire;

    assign rd = (r_phase == PH_ROM_DATA && r_rom_cmd == owt_pkg::ROM_READ) ||
                (r_phase == PH_FN_DATA && r_fn_cmd == owt_pkg::FN_READ);

    always_comb begin
        asm_upd = r_asm;
        crc_upd = r_crc;
        if (rd) begin
            asm_upd = r_asm | ({7'd0, i_req.echo_one} << r_bit_pos);
            if (r_phase == PH_FN_DATA) begin
                crc_upd = (r_crc >> 1) ^
                          (((r_crc[0] ^ i_req.echo_one)) ? owt_pkg::CRC_POLY : 8'h00);
            end
        end
    end

    assign sp_count = (r_fn_cmd == owt_pkg::FN_READ) ? 4'(owt_pkg::SP_READ_BYTES)
                                                     : 4'(owt_pkg::SP_WRITE_BYTES);

    always_comb begin
        n_phase    = r_phase;
        n_bit_pos  = r_bit_pos;
        n_byte_pos = r_byte_pos;
        n_asm      = r_asm;
        n_send     = r_send;
        n_rom_cmd  = r_rom_cmd;
        n_fn_cmd   = r_fn_cmd;
        n_crc      = r_crc;
        res        = '0;
        has_res    = 1'b0;
        go         = 1'b0;
        go_ph      = PH_IDLE;
        go_rd      = 1'b0;
        sel        = r_send;

        if (fire) begin
            case (i_req.op)
                owt_pkg::OP_START: begin
                    n_rom_cmd           = i_req.rom_command;
                    n_fn_cmd            = i_req.function_command;
                    n_bit_pos           = 3'd0;
                    n_byte_pos          = 4'd0;
                    n_asm               = 8'd0;
                    n_send              = owt_pkg::RESET_CHAR;
                    n_crc               = 8'd0;
                    n_phase             = PH_PRESENCE;
                    has_res             = 1'b1;
                    res.line_char_valid = 1'b1;
                    res.line_char       = owt_pkg::RESET_CHAR;
                    res.slow_rate       = 1'b1;
                end
                owt_pkg::OP_ECHO: begin
                    if (r_phase == PH_PRESENCE) begin
                        has_res = 1'b1;
                        if (i_req.echo_reset) begin
                            // reset char came back untouched: nobody on the bus
                            res.no_device = 1'b1;
                            n_phase       = PH_IDLE;
                        end else begin
                            go    = 1'b1;
                            go_ph = PH_ROM_CMD;
                        end
                    end else if (r_phase != PH_IDLE) begin
                        has_res = 1'b1;
                        n_asm   = asm_upd;
                        n_crc   = crc_upd;
                        if (r_bit_pos != 3'd7) begin
                            n_bit_pos           = r_bit_pos + 3'd1;
                            res.line_char_valid = 1'b1;
                            res.line_char       = r_send[n_bit_pos] ? owt_pkg::ONE_CHAR
                                                                    : owt_pkg::ZERO_CHAR;
                        end else begin
                            if (rd) begin
                                res.read_valid    = 1'b1;
                                res.read_byte     = asm_upd;
                                res.read_from_rom = (r_phase == PH_ROM_DATA);
                                res.read_index    = r_byte_pos;
                            end
                            case (r_phase)
                                PH_ROM_CMD: begin
                                    n_byte_pos = 4'd0;
                                    go         = 1'b1;
                                    go_ph      = (r_rom_cmd == owt_pkg::ROM_MATCH ||
                                                  r_rom_cmd == owt_pkg::ROM_READ)
                                                 ? PH_ROM_DATA : PH_FN_CMD;
                                end
                                PH_ROM_DATA: begin
                                    n_byte_pos = r_byte_pos + 4'd1;
                                    go         = 1'b1;
                                    go_ph      = (n_byte_pos < 4'(owt_pkg::ROM_BYTES))
                                                 ? PH_ROM_DATA : PH_FN_CMD;
                                end
                                PH_FN_CMD: begin
                                    n_byte_pos = 4'd0;
                                    n_crc      = 8'd0;
                                    if (r_fn_cmd == owt_pkg::FN_WRITE ||
                                        r_fn_cmd == owt_pkg::FN_READ) begin
                                        go    = 1'b1;
                                        go_ph = PH_FN_DATA;
                                    end else begin
                                        res.finished = 1'b1;
                                        n_phase      = PH_IDLE;
                                    end
                                end
                                default: begin
                                    n_byte_pos = r_byte_pos + 4'd1;
                                    if (n_byte_pos < sp_count) begin
                                        go    = 1'b1;
                                        go_ph = PH_FN_DATA;
                                    end else begin
                                        res.finished = 1'b1;
                                        res.crc_good = (r_fn_cmd == owt_pkg::FN_READ) &&
                                                       (crc_upd == 8'd0);
                                        n_phase      = PH_IDLE;
                                    end
                                end
                            endcase
                        end
                    end
                end
                default: ;   // loads are handled by the store below
            endcase
        end

        if (go) begin
            go_rd = (go_ph == PH_ROM_DATA && r_rom_cmd == owt_pkg::ROM_READ) ||
                    (go_ph == PH_FN_DATA && r_fn_cmd == owt_pkg::FN_READ);
            case (go_ph)
                PH_ROM_CMD: sel = r_rom_cmd;
                PH_FN_CMD:  sel = r_fn_cmd;
                default:    sel = go_rd ? owt_pkg::ONE_CHAR : r_rd_data;
            endcase
            n_phase             = go_ph;
            n_bit_pos           = 3'd0;
            n_asm               = 8'd0;
            n_send              = sel;
            res.line_char_valid = 1'b1;
            res.line_char       = sel[0] ? owt_pkg::ONE_CHAR : owt_pkg::ZERO_CHAR;
        end
    end

    // store address the next byte phase will fetch, read into a register ahead of use
    always_comb begin
        case (n_phase)
            PH_ROM_DATA: pa = FW'(n_byte_pos) + FW'(1);
            PH_FN_CMD:   pa = FW'(owt_pkg::SP_BASE);
            PH_FN_DATA:  pa = FW'(owt_pkg::SP_BASE) + FW'(n_byte_pos) + FW'(1);
            default:     pa = '0;
        endcase
    end

    assign pa_ok    = (int'(pa) < STORE_DEPTH);
    assign st_we    = fire && (i_req.op == owt_pkg::OP_LOAD) &&
                      (int'(i_req.write_index) < STORE_DEPTH);
    assign st_waddr = AW'(i_req.write_index);

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= i_req.write_value;
        end
        if (!pa_ok) begin
            r_rd_data <= 8'd0;
        end else if (st_we && st_waddr == pa[AW-1:0]) begin
            r_rd_data <= i_req.write_value;
        end else begin
            r_rd_data <= r_store[pa[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_pos   <= 3'd0;
            r_byte_pos  <= 4'd0;
            r_asm       <= 8'd0;
            r_send      <= 8'd0;
            r_rom_cmd   <= 8'd0;
            r_fn_cmd    <= 8'd0;
            r_crc       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_bit_pos  <= n_bit_pos;
            r_byte_pos <= n_byte_pos;
            r_asm      <= n_asm;
            r_send     <= n_send;
            r_rom_cmd  <= n_rom_cmd;
            r_fn_cmd   <= n_fn_cmd;
            r_crc      <= n_crc;
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= fire && has_res;
                r_out       <= res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> src/onewire_transaction_sequencer.sv
// Top level of the one-wire transaction sequencer
// One request is taken per clock while the four-entry request queue has room;
// the back-end state machine retires one queued request per cycle while its
// result register is not stalled, so the sustained rate is one request per
// cycle. A taken request is written into the queue first; the back end pops
// it from there and registers its result in the output register, where the
// result is held while stalled.
// Start, echo and load requests share the queue, so loads land in the write
// store in order with the echoes that fetch from it. Each line character is
// to be sent at 9600 baud when slow_rate is set (reset slot) and at 115200
// baud otherwise.
module onewire_transaction_sequencer #(
    parameter int STORE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  owt_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output owt_pkg::t_out_item o_out,
    input  logic               i_out_stall
);

    logic          push;
    logic          full;
    logic          q_valid;
    logic          pop;
    owt_pkg::t_req front_req;
    owt_pkg::t_req q_req;

    owt_front u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_req      (front_req)
    );

    owt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (pop)
    );

    owt_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_req       (q_req),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> src/owt_checker.sv
// Port-level checker for the one-wire transaction sequencer, with its bind
`include "onewire_transaction_sequencer_macros.svh"

module owt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input owt_pkg::t_in_item  i_in,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input owt_pkg::t_out_item o_out,
    input logic               i_out_stall
);

    logic out_held;
    logic abort_extra;

    assign out_held    = o_out_valid && i_out_stall;
    assign abort_extra = o_out.finished || o_out.line_char_valid || o_out.read_valid;

    // a stalled result holds
    `OWT_ASSERT_NEXT(a_out_hold, i_clk, out_held, o_out_valid && $stable(o_out), i_rst_n)

    // nothing pending and no stall straight after reset
    `OWT_ASSERT_ALWAYS(a_reset_clear, i_clk, !$past(i_rst_n), !o_out_valid && !o_in_stall)

    // full queue with a blocked result cannot drain
    `OWT_ASSERT_NEXT(a_full_holds, i_clk, o_in_stall && out_held, o_in_stall, i_rst_n)

    // an abort result carries nothing else
    `OWT_ASSERT_IMPLY(a_abort_alone, i_clk, i_rst_n, o_out_valid && o_out.no_device, !abort_extra)

endmodule

bind onewire_transaction_sequencer owt_checker u_owt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in        (i_in),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out       (o_out),
    .i_out_stall (i_out_stall)
);
